// File: design/pce_pkg.sv
// Shared types, codes, field widths and width helpers for the Pearson correlation engine.
`timescale 1ns / 1ps

package pce_pkg;

	// default build parameters
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_LEN_DEF     = 4096;

	// fixed field widths of the channels
	localparam int SAMPLE_W = 16;
	localparam int CORR_W   = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 13;

	// Q1.14 result and its bit-at-a-time search
	localparam int FRAC_BITS = 14;
	localparam int MAG_W     = FRAC_BITS + 1;
	localparam int STEP_W    = 4;

	// depth of the queue of finished series sums
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_VALID    = 2'd0,
		STATUS_UNDEF    = 2'd1,
		STATUS_OVERLONG = 2'd2
	} status_t;

	// products formed by the back end, in issue order
	typedef enum logic [2:0] {
		OP_N_SAA = 3'd0,
		OP_SA_SA = 3'd1,
		OP_N_SBB = 3'd2,
		OP_SB_SB = 3'd3,
		OP_N_SAB = 3'd4,
		OP_SA_SB = 3'd5,
		OP_VA_VB = 3'd6,
		OP_NUM_SQ = 3'd7
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ISSUE  = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_SEARCH = 5'b01000,
		ST_OUT    = 5'b10000
	} back_state_t;

	function automatic int cnt_w(input int ml);
		return $clog2(ml + 1);
	endfunction

	function automatic int sum_w(input int sb, input int ml);
		return (sb + $clog2(ml) > 64) ? 64 : sb + $clog2(ml);
	endfunction

	// sums of products wrap at 64 bits for very large builds
	function automatic int sq_w(input int sb, input int ml);
		return (2 * sb + $clog2(ml) > 64) ? 64 : 2 * sb + $clog2(ml);
	endfunction

	function automatic int snap_w(input int sb, input int ml);
		return 1 + cnt_w(ml) + 2 * sum_w(sb, ml) + 3 * sq_w(sb, ml);
	endfunction

	// operand width of the back-end multiplier: holds n * sum of squares
	function automatic int var_w(input int sb, input int ml);
		return cnt_w(ml) + sq_w(sb, ml);
	endfunction

endpackage

// File: design/pce_pair_if.sv
// Channel carrying one pair of samples per word.
`timescale 1ns / 1ps

interface pce_pair_if;
	logic                          valid;
	logic                          ready;
	logic [pce_pkg::SAMPLE_W-1:0]  sample_a;
	logic [pce_pkg::SAMPLE_W-1:0]  sample_b;
	logic                          last;

	modport source (output valid, output sample_a, output sample_b, output last, input ready);
	modport sink   (input valid, input sample_a, input sample_b, input last, output ready);
endinterface

// File: design/pce_result_if.sv
// Channel carrying one correlation result per word.
`timescale 1ns / 1ps

interface pce_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [pce_pkg::CORR_W-1:0]  correlation;
	logic [pce_pkg::STATUS_W-1:0]       status;
	logic [pce_pkg::COUNT_W-1:0]        pair_count;

	modport source (output valid, output correlation, output status, output pair_count,
		input ready);
	modport sink   (input valid, input correlation, input status, input pair_count,
		output ready);
endinterface

// File: design/pearson_correlation_engine_core.sv
// Top level of the Pearson correlation engine: front end, series queue and back end.
`timescale 1ns / 1ps

// Pearson correlation engine. Pairs of unsigned samples arrive on the pairs
// channel, one pair per word and one word per clock at full rate; the front
// end forms the three products in a registered stage and adds them into the
// count, the two sums, the cross sum and the two sums of squares. The word
// marked last closes a series: its sums go into a two-entry queue and the
// accumulators clear, so the next series can start in the following cycle.
// Pairs past MAX_LEN are dropped from the sums and the series is reported
// with status 2 (overlong), still carrying the coefficient of the kept pairs.
// The back end takes one series at a time and computes the coefficient
// exactly in signed Q1.14, rounded toward zero: eight products on a shared
// shift-and-add multiplier of VW = clog2(MAX_LEN+1) + 2*SAMPLE_BITS +
// clog2(MAX_LEN) bits (57 at the defaults), then a 15-step magnitude
// search, one bit per cycle. When a variance is zero, the back end stops
// after four products (status 1, coefficient 0). While the back end works,
// the front keeps taking pairs; it stalls only when a series ends with both
// queue entries taken. The result waits in its register until taken on the
// result channel; pair_count gives the pairs kept in the sums.

module pearson_correlation_engine_core #(
	parameter int SAMPLE_BITS = pce_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_LEN     = pce_pkg::MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pce_pair_if.sink      pairs,
	pce_result_if.source  result
);
	localparam int QW = pce_pkg::snap_w(SAMPLE_BITS, MAX_LEN);

	logic          snap_push, snap_full;
	logic [QW-1:0] snap_in;
	logic          snap_pop, snap_valid;
	logic [QW-1:0] snap_out;

	pce_front #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_LEN(MAX_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pairs     (pairs),
		.snap_push (snap_push),
		.snap_data (snap_in),
		.snap_full (snap_full)
	);

	// finished series sums, two deep
	pce_queue #(.WIDTH(QW), .DEPTH(pce_pkg::QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (snap_push),
		.push_data  (snap_in),
		.full       (snap_full),
		.pop        (snap_pop),
		.head_valid (snap_valid),
		.head_data  (snap_out)
	);

	pce_back #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_LEN(MAX_LEN)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_data  (snap_out),
		.snap_pop   (snap_pop),
		.result     (result)
	);

endmodule

// File: design/pce_front.sv
// Front end: takes pairs, forms products, accumulates sums and emits a snapshot per series.
`timescale 1ns / 1ps

module pce_front #(
	parameter int SAMPLE_BITS = pce_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_LEN     = pce_pkg::MAX_LEN_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	pce_pair_if.sink                                         pairs,
	output logic                                             snap_push,
	output logic [pce_pkg::snap_w(SAMPLE_BITS, MAX_LEN)-1:0] snap_data,
	input  logic                                             snap_full
);
	localparam int SB  = SAMPLE_BITS;
	localparam int CW  = pce_pkg::cnt_w(MAX_LEN);
	localparam int SW  = pce_pkg::sum_w(SAMPLE_BITS, MAX_LEN);
	localparam int SQW = pce_pkg::sq_w(SAMPLE_BITS, MAX_LEN);
	localparam int PW  = 2 * SB;

	logic [CW-1:0]  cnt_q;
	logic           keep;
	logic           accept;
	logic           go;

	logic           valid_s1;
	logic           last_s1;
	logic           keep_s1;
	logic [CW-1:0]  cnt_s1;
	logic [SB-1:0]  a_s1, b_s1;
	logic [PW-1:0]  ab_s1, aa_s1, bb_s1;

	logic [SW-1:0]  sa_q, sb_q, sa_n, sb_n;
	logic [SQW-1:0] sab_q, saa_q, sbb_q, sab_n, saa_n, sbb_n;
	logic           ovf_q, ovf_n;
	logic [SB-1:0]  a_in, b_in;

	assign a_in   = SB'(pairs.sample_a);
	assign b_in   = SB'(pairs.sample_b);
	assign keep   = (cnt_q < CW'(MAX_LEN));
	assign go     = valid_s1 && (!last_s1 || !snap_full);
	assign pairs.ready = !valid_s1 || go;
	assign accept = pairs.valid && pairs.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= pairs.last ? '0 : (keep ? cnt_q + 1'b1 : cnt_q);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= pairs.last;
			keep_s1 <= keep;
			cnt_s1  <= keep ? cnt_q + 1'b1 : cnt_q;
			a_s1    <= a_in;
			b_s1    <= b_in;
			ab_s1   <= PW'(a_in) * PW'(b_in);
			aa_s1   <= PW'(a_in) * PW'(a_in);
			bb_s1   <= PW'(b_in) * PW'(b_in);
		end
	end

	always_comb begin
		sa_n  = sa_q  + (keep_s1 ? SW'(a_s1)   : '0);
		sb_n  = sb_q  + (keep_s1 ? SW'(b_s1)   : '0);
		sab_n = sab_q + (keep_s1 ? SQW'(ab_s1) : '0);
		saa_n = saa_q + (keep_s1 ? SQW'(aa_s1) : '0);
		sbb_n = sbb_q + (keep_s1 ? SQW'(bb_s1) : '0);
		ovf_n = ovf_q | !keep_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q  <= '0;
			sb_q  <= '0;
			sab_q <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			ovf_q <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				sa_q  <= '0;
				sb_q  <= '0;
				sab_q <= '0;
				saa_q <= '0;
				sbb_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sa_q  <= sa_n;
				sb_q  <= sb_n;
				sab_q <= sab_n;
				saa_q <= saa_n;
				sbb_q <= sbb_n;
				ovf_q <= ovf_n;
			end
		end
	end

	assign snap_push = go && last_s1;
	assign snap_data = {ovf_n, cnt_s1, sa_n, sb_n, sab_n, saa_n, sbb_n};

endmodule

// File: design/pce_queue.sv
// Short register queue holding finished series sums between front and back end.
`timescale 1ns / 1ps

module pce_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pce_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [FW-1:0]    fill_q;
	logic             do_push, do_pop;

	assign full       = (fill_q == FW'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_data  = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

// File: design/pce_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module pce_mul #(
	parameter int WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   op_a,
	input  logic [WIDTH-1:0]   op_b,
	output logic               done,
	output logic [2*WIDTH-1:0] prod
);
	localparam int NW = $clog2(WIDTH + 1);

	logic [2*WIDTH-1:0] mcand_q;
	logic [WIDTH-1:0]   mplier_q;
	logic [NW-1:0]      left_q;
	logic               run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done   <= 1'b0;
			left_q <= '0;
		end else begin
			done <= run_q && (left_q == NW'(1));
			if (start) begin
				run_q  <= 1'b1;
				left_q <= NW'(WIDTH);
			end else if (run_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == NW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod     <= '0;
			mcand_q  <= (2 * WIDTH)'(op_a);
			mplier_q <= op_b;
		end else if (run_q) begin
			if (mplier_q[0]) begin
				prod <= prod + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

// File: design/pce_back.sv
// Back end: variances, covariance and the exact Q1.14 coefficient search for one series.
`timescale 1ns / 1ps

module pce_back #(
	parameter int SAMPLE_BITS = pce_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_LEN     = pce_pkg::MAX_LEN_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             snap_valid,
	input  logic [pce_pkg::snap_w(SAMPLE_BITS, MAX_LEN)-1:0] snap_data,
	output logic                                             snap_pop,
	pce_result_if.source                                     result
);
	localparam int CW  = pce_pkg::cnt_w(MAX_LEN);
	localparam int SW  = pce_pkg::sum_w(SAMPLE_BITS, MAX_LEN);
	localparam int SQW = pce_pkg::sq_w(SAMPLE_BITS, MAX_LEN);
	localparam int VW  = pce_pkg::var_w(SAMPLE_BITS, MAX_LEN);
	localparam int PW  = 2 * VW;
	localparam int TW  = PW + 2 * pce_pkg::FRAC_BITS + 2;
	localparam int MW  = pce_pkg::MAG_W;

	pce_pkg::back_state_t state_q;
	pce_pkg::op_t         op_q;

	logic           in_ovf;
	logic [CW-1:0]  in_cnt;
	logic [SW-1:0]  in_sa, in_sb;
	logic [SQW-1:0] in_sab, in_saa, in_sbb;

	logic [CW-1:0]  cnt_q;
	logic [SW-1:0]  sa_q, sb_q;
	logic [SQW-1:0] sab_q, saa_q, sbb_q;
	logic           ovf_q;

	logic [PW-1:0]  hold_q;
	logic [VW-1:0]  va_q, vb_q, num_q;
	logic           neg_q, zvar_q;
	logic [PW-1:0]  den_q;
	logic [TW-1:0]  tgt_q, p_q, qs_q, ds_q;
	logic [MW-1:0]  mag_q;
	logic [pce_pkg::STEP_W-1:0] k_q;

	logic           mul_start, mul_done;
	logic [VW-1:0]  mul_a, mul_b;
	logic [PW-1:0]  prod;

	logic [TW+1:0]  trial;
	logic           cap_ok, take;
	logic [MW-1:0]  bit_k;

	logic signed [pce_pkg::CORR_W-1:0] corr_q;
	logic [pce_pkg::STATUS_W-1:0]      status_q;
	logic [pce_pkg::COUNT_W-1:0]       count_q;

	assign {in_ovf, in_cnt, in_sa, in_sb, in_sab, in_saa, in_sbb} = snap_data;
	assign snap_pop  = (state_q == pce_pkg::ST_IDLE) && snap_valid;
	assign mul_start = (state_q == pce_pkg::ST_ISSUE);

	always_comb begin
		unique case (op_q)
			pce_pkg::OP_N_SAA:  begin mul_a = VW'(cnt_q); mul_b = VW'(saa_q); end
			pce_pkg::OP_SA_SA:  begin mul_a = VW'(sa_q);  mul_b = VW'(sa_q);  end
			pce_pkg::OP_N_SBB:  begin mul_a = VW'(cnt_q); mul_b = VW'(sbb_q); end
			pce_pkg::OP_SB_SB:  begin mul_a = VW'(sb_q);  mul_b = VW'(sb_q);  end
			pce_pkg::OP_N_SAB:  begin mul_a = VW'(cnt_q); mul_b = VW'(sab_q); end
			pce_pkg::OP_SA_SB:  begin mul_a = VW'(sa_q);  mul_b = VW'(sb_q);  end
			pce_pkg::OP_VA_VB:  begin mul_a = va_q;       mul_b = vb_q;       end
			pce_pkg::OP_NUM_SQ: begin mul_a = num_q;      mul_b = num_q;      end
			default:            begin mul_a = '0;         mul_b = '0;         end
		endcase
	end

	pce_mul #(.WIDTH(VW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// one magnitude bit per step; q never passes one in Q1.14
	assign bit_k  = MW'(1) << k_q;
	assign trial  = (TW + 2)'(p_q) + (TW + 2)'(qs_q) + (TW + 2)'(ds_q);
	assign cap_ok = (k_q == pce_pkg::STEP_W'(pce_pkg::FRAC_BITS)) || !mag_q[MW-1];
	assign take   = cap_ok && (trial <= (TW + 2)'(tgt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pce_pkg::ST_IDLE;
			op_q    <= pce_pkg::OP_N_SAA;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				pce_pkg::ST_IDLE: begin
					if (snap_valid) begin
						state_q <= pce_pkg::ST_ISSUE;
						op_q    <= pce_pkg::OP_N_SAA;
					end
				end
				pce_pkg::ST_ISSUE: begin
					state_q <= pce_pkg::ST_MUL;
				end
				pce_pkg::ST_MUL: begin
					if (mul_done) begin
						if (op_q == pce_pkg::OP_NUM_SQ) begin
							state_q <= pce_pkg::ST_SEARCH;
							k_q     <= pce_pkg::STEP_W'(pce_pkg::FRAC_BITS);
						end else if (op_q == pce_pkg::OP_SB_SB &&
							(zvar_q || hold_q <= prod)) begin
							state_q <= pce_pkg::ST_OUT;
						end else begin
							state_q <= pce_pkg::ST_ISSUE;
							op_q    <= pce_pkg::op_t'(op_q + 3'd1);
						end
					end
				end
				pce_pkg::ST_SEARCH: begin
					k_q <= k_q - 1'b1;
					if (k_q == '0) begin
						state_q <= pce_pkg::ST_OUT;
					end
				end
				pce_pkg::ST_OUT: begin
					if (result.ready) begin
						state_q <= pce_pkg::ST_IDLE;
					end
				end
				default: state_q <= pce_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (snap_pop) begin
			cnt_q  <= in_cnt;
			sa_q   <= in_sa;
			sb_q   <= in_sb;
			sab_q  <= in_sab;
			saa_q  <= in_saa;
			sbb_q  <= in_sbb;
			ovf_q  <= in_ovf;
			zvar_q <= 1'b0;
		end
		if (state_q == pce_pkg::ST_MUL && mul_done) begin
			unique case (op_q)
				pce_pkg::OP_N_SAA, pce_pkg::OP_N_SBB, pce_pkg::OP_N_SAB: begin
					hold_q <= prod;
				end
				pce_pkg::OP_SA_SA: begin
					if (hold_q <= prod) zvar_q <= 1'b1;
					va_q <= VW'(hold_q - prod);
				end
				pce_pkg::OP_SB_SB: begin
					if (hold_q <= prod) zvar_q <= 1'b1;
					vb_q <= VW'(hold_q - prod);
				end
				pce_pkg::OP_SA_SB: begin
					neg_q <= (hold_q < prod);
					num_q <= (hold_q < prod) ? VW'(prod - hold_q) : VW'(hold_q - prod);
				end
				pce_pkg::OP_VA_VB: begin
					den_q <= prod;
				end
				pce_pkg::OP_NUM_SQ: begin
					tgt_q <= TW'(prod) << (2 * pce_pkg::FRAC_BITS);
					p_q   <= '0;
					qs_q  <= '0;
					ds_q  <= TW'(den_q) << (2 * pce_pkg::FRAC_BITS);
					mag_q <= '0;
				end
				default: hold_q <= hold_q;
			endcase
		end
		if (state_q == pce_pkg::ST_SEARCH) begin
			// P = q^2 D, qs = (q D) << (k+1), ds = D << 2k
			if (take) begin
				p_q   <= TW'(trial);
				mag_q <= mag_q | bit_k;
			end
			qs_q <= (qs_q >> 1) + (take ? ds_q : '0);
			ds_q <= ds_q >> 2;
		end
	end

	// result word, captured as the back end finishes
	always_ff @(posedge clk) begin
		if (state_q == pce_pkg::ST_MUL && mul_done && op_q == pce_pkg::OP_SB_SB &&
			(zvar_q || hold_q <= prod)) begin
			corr_q   <= '0;
			status_q <= ovf_q ? pce_pkg::STATUS_OVERLONG : pce_pkg::STATUS_UNDEF;
			count_q  <= pce_pkg::COUNT_W'(cnt_q);
		end else if (state_q == pce_pkg::ST_SEARCH && k_q == '0) begin
			corr_q   <= neg_q ? -$signed(pce_pkg::CORR_W'(mag_q | (take ? bit_k : '0)))
				: $signed(pce_pkg::CORR_W'(mag_q | (take ? bit_k : '0)));
			status_q <= ovf_q ? pce_pkg::STATUS_OVERLONG : pce_pkg::STATUS_VALID;
			count_q  <= pce_pkg::COUNT_W'(cnt_q);
		end
	end

	assign result.valid       = (state_q == pce_pkg::ST_OUT);
	assign result.correlation = corr_q;
	assign result.status      = status_q;
	assign result.pair_count  = count_q;

endmodule

// File: tb/tb.sv
// Testbench for the Pearson correlation engine: table-driven and random series, self-checked.
`timescale 1ns / 1ps

module tb;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1200;
	localparam int RANDOM_WORDS = 1510;

	typedef logic [255:0] wide_t;

	typedef struct {
		logic signed [pce_pkg::CORR_W-1:0] correlation;
		pce_pkg::status_t                  status;
		logic [pce_pkg::COUNT_W-1:0]       pair_count;
	} corr_result_t;

	typedef struct {
		logic [pce_pkg::SAMPLE_W-1:0] a;
		logic [pce_pkg::SAMPLE_W-1:0] b;
		logic                         last;
		bit                           typed;
		corr_result_t                 res;
	} pair_row_t;

	logic clk;
	logic arst_n;

	pce_pair_if   pairs();
	pce_result_if result();

	pearson_correlation_engine_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// running sums of the open series
	int          acc_n;
	logic [63:0] acc_a, acc_b, acc_ab, acc_aa, acc_bb;
	bit          acc_over;

	corr_result_t pending_results[$];
	pair_row_t    table_rows[$];
	int           mismatches;
	bit           hold_req;
	bit           no_gap;
	int           idle_cycles;

	function automatic bit spread(input logic [63:0] s, input logic [63:0] sq,
		output wide_t v);
		wide_t p, q;
		p = wide_t'(acc_n) * wide_t'(sq);
		q = wide_t'(s) * wide_t'(s);
		v = p - q;
		return p > q;
	endfunction

	// folds one pair into the sums; on a closing pair returns the coefficient
	function automatic bit accumulate_pair(input logic [pce_pkg::SAMPLE_W-1:0] a,
		input logic [pce_pkg::SAMPLE_W-1:0] b, input logic last, output corr_result_t r);
		wide_t va, vb, x, y, mag, target, den;
		int lo, hi, mid;
		bit neg;
		if (acc_n < pce_pkg::MAX_LEN_DEF) begin
			acc_n++;
			acc_a  += 64'(a);
			acc_b  += 64'(b);
			acc_ab += 64'(a) * 64'(b);
			acc_aa += 64'(a) * 64'(a);
			acc_bb += 64'(b) * 64'(b);
		end else begin
			acc_over = 1'b1;
		end
		if (!last)
			return 1'b0;
		r.correlation = '0;
		r.status = pce_pkg::STATUS_UNDEF;
		if (spread(acc_a, acc_aa, va) && spread(acc_b, acc_bb, vb)) begin
			x = wide_t'(acc_n) * wide_t'(acc_ab);
			y = wide_t'(acc_a) * wide_t'(acc_b);
			neg = x < y;
			mag = neg ? y - x : x - y;
			target = (mag * mag) << 28;
			den = va * vb;
			lo = 0;
			hi = 16384;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (wide_t'(mid * mid) * den <= target)
					lo = mid;
				else
					hi = mid - 1;
			end
			r.correlation = neg ? -16'(lo) : 16'(lo);
			r.status = pce_pkg::STATUS_VALID;
		end
		if (acc_over)
			r.status = pce_pkg::STATUS_OVERLONG;
		r.pair_count = pce_pkg::COUNT_W'(acc_n);
		acc_n = 0;
		acc_a = '0; acc_b = '0; acc_ab = '0; acc_aa = '0; acc_bb = '0;
		acc_over = 1'b0;
		return 1'b1;
	endfunction

	// offers one word and waits for it to be taken
	task automatic send_pair(input logic [pce_pkg::SAMPLE_W-1:0] a,
		input logic [pce_pkg::SAMPLE_W-1:0] b,
		input logic last, input bit typed, input corr_result_t typed_res);
		int gap;
		corr_result_t r;
		gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			pairs.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pairs.valid    <= 1'b1;
		pairs.sample_a <= a;
		pairs.sample_b <= b;
		pairs.last     <= last;
		do @(posedge clk); while (!pairs.ready);
		if (accumulate_pair(a, b, last, r))
			pending_results.insert(pending_results.size(), typed ? typed_res : r);
	endtask

	task automatic send_series(input int len, input int kind);
		logic [pce_pkg::SAMPLE_W-1:0] a, b, base;
		corr_result_t none;
		none.correlation = '0;
		none.status = pce_pkg::STATUS_VALID;
		none.pair_count = '0;
		base = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			a = 16'($urandom);
			case (kind)
				1: b = a + 16'($urandom_range(0, 255));
				2: b = ~a ^ 16'($urandom_range(0, 63));
				3: begin
					a = base;
					b = 16'($urandom);
				end
				4: begin
					a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				end
				default: b = 16'($urandom);
			endcase
			send_pair(a, b, i == len - 1, 1'b0, none);
		end
	endtask

	task automatic add_row(input logic [15:0] a, input logic [15:0] b, input logic last,
		input bit typed, input int corr, input pce_pkg::status_t st, input int n);
		pair_row_t row;
		row.a = a;
		row.b = b;
		row.last = last;
		row.typed = typed;
		row.res.correlation = 16'(corr);
		row.res.status = st;
		row.res.pair_count = pce_pkg::COUNT_W'(n);
		table_rows.insert(table_rows.size(), row);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		result.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				result.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// result checker and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pairs.valid && pairs.ready) || (result.valid && result.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
			if (result.valid && result.ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result corr=%0d status=%0d n=%0d",
							result.correlation, result.status, result.pair_count);
				end else begin
					corr_result_t e;
					e = pending_results.pop_front();
					if (result.correlation !== e.correlation || result.status !== e.status
						|| result.pair_count !== e.pair_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp corr=%0d status=%0d n=%0d,",
								e.correlation, e.status, e.pair_count,
								" got corr=%0d status=%0d n=%0d",
								result.correlation, result.status, result.pair_count);
					end
				end
			end
		end
	end

	initial begin
		int sent, len;
		mismatches = 0;
		idle_cycles = 0;
		hold_req = 1'b0;
		no_gap = 1'b0;
		acc_n = 0;
		acc_a = '0; acc_b = '0; acc_ab = '0; acc_aa = '0; acc_bb = '0;
		acc_over = 1'b0;
		pairs.valid = 1'b0;
		pairs.sample_a = '0;
		pairs.sample_b = '0;
		pairs.last = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single pair: no variance
		add_row(16'hFFFF, 16'h0000, 1, 1, 0, pce_pkg::STATUS_UNDEF, 1);
		// two extreme pairs, perfectly correlated
		add_row(16'h0000, 16'h0000, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'hFFFF, 16'hFFFF, 1, 1, 16384, pce_pkg::STATUS_VALID, 2);
		// perfectly anticorrelated
		add_row(16'h0000, 16'hFFFF, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'hFFFF, 16'h0000, 1, 1, -16384, pce_pkg::STATUS_VALID, 2);
		// first series constant
		add_row(16'd5, 16'd7, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'd5, 16'd9, 1, 1, 0, pce_pkg::STATUS_UNDEF, 2);
		// second series constant at full scale
		add_row(16'd1, 16'hFFFF, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'd2, 16'hFFFF, 1, 1, 0, pce_pkg::STATUS_UNDEF, 2);
		// general rows, predicted
		add_row(16'd100, 16'd300, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'd200, 16'd100, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'd50, 16'd60000, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'hAAAA, 16'h5555, 1, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'h8000, 16'h0001, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'h7FFF, 16'h8000, 0, 0, 0, pce_pkg::STATUS_VALID, 0);
		add_row(16'h1234, 16'h1235, 1, 0, 0, pce_pkg::STATUS_VALID, 0);
		foreach (table_rows[i])
			send_pair(table_rows[i].a, table_rows[i].b, table_rows[i].last,
				table_rows[i].typed, table_rows[i].res);

		// long receiver hold-off while short series keep coming: the queue fills
		no_gap = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_series(2, i % 5);
		no_gap = 1'b0;

		// sender pause until the block has drained
		pairs.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 19))
				0, 1: len = 1;
				2: len = $urandom_range(60, 200);
				default: len = $urandom_range(2, 30);
			endcase
			no_gap = ($urandom_range(0, 5) == 0);
			send_series(len, $urandom_range(0, 5));
			sent += len;
		end
		pairs.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
design/pce_pkg.sv
design/pce_pair_if.sv
design/pce_result_if.sv
design/pce_front.sv
design/pce_queue.sv
design/pce_mul.sv
design/pce_back.sv
design/pearson_correlation_engine_core.sv
tb/tb.sv
